// File: rtl/ntd_pkg.sv
// Shared types, constants and helper functions of the mesh traffic destination block.
package ntd_pkg;

    // Node count cap used when the address width is worked out.
    localparam int MAX_NODES = 256;

    localparam int NODE_W  = 8;
    localparam int DIM_W   = 5;
    localparam int COORD_W = 4;
    localparam int NBITS_W = 4;
    localparam int RECIP_W = 13;
    localparam int RECIP_SHIFT = 12;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MESH_WIDTH      = 2'd0;
    localparam logic [1:0] CFG_MESH_HEIGHT     = 2'd1;
    localparam logic [1:0] CFG_TRAFFIC_PATTERN = 2'd2;

    typedef enum logic [2:0] {
        PAT_TRANSPOSE1 = 3'd0,
        PAT_TRANSPOSE2 = 3'd1,
        PAT_BIT_REV    = 3'd2,
        PAT_SHUFFLE    = 3'd3,
        PAT_BUTTERFLY  = 3'd4
    } ntd_pattern_t;

    localparam logic [DIM_W-1:0] MESH_WIDTH_RST  = 5'd4;
    localparam logic [DIM_W-1:0] MESH_HEIGHT_RST = 5'd4;

    // Coordinates of one word after the divide stage.
    typedef struct packed {
        logic [NODE_W-1:0]  src;
        logic [COORD_W-1:0] sx;
        logic [NODE_W-1:0]  sy;
    } ntd_coord_t;

    // A zero dimension counts as one, anything above sixteen as sixteen.
    function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = 5'd1;
        else if (v > 5'd16)
            r = 5'd16;
        else
            r = v;
        return r;
    endfunction

    // floor(4096 / w) for the legal mesh widths.
    function automatic logic [RECIP_W-1:0] recip(input logic [DIM_W-1:0] w);
        logic [RECIP_W-1:0] r;
        case (w)
            5'd1:    r = 13'd4096;
            5'd2:    r = 13'd2048;
            5'd3:    r = 13'd1365;
            5'd4:    r = 13'd1024;
            5'd5:    r = 13'd819;
            5'd6:    r = 13'd682;
            5'd7:    r = 13'd585;
            5'd8:    r = 13'd512;
            5'd9:    r = 13'd455;
            5'd10:   r = 13'd409;
            5'd11:   r = 13'd372;
            5'd12:   r = 13'd341;
            5'd13:   r = 13'd315;
            5'd14:   r = 13'd292;
            5'd15:   r = 13'd273;
            default: r = 13'd256;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/ntd_src_if.sv
// Handshake channel that carries source node words into the block.
interface ntd_src_if;
    logic                      valid;
    logic                      ready;
    logic [ntd_pkg::NODE_W-1:0] source_node;

    modport source (output valid, output source_node, input ready);
    modport sink (input valid, input source_node, output ready);
endinterface

// File: rtl/ntd_dst_if.sv
// Handshake channel that carries destination node words out of the block.
interface ntd_dst_if;
    logic                      valid;
    logic                      ready;
    logic [ntd_pkg::NODE_W-1:0] dest_node;

    modport source (output valid, output dest_node, input ready);
    modport sink (input valid, input dest_node, output ready);
endinterface

// File: rtl/ntd_divmod.sv
// Two-stage pipelined split of a node id into mesh column and row.
module ntd_divmod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ntd_pkg::NODE_W-1:0]    in_src,
    input  logic [ntd_pkg::DIM_W-1:0]     width,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ntd_pkg::ntd_coord_t           out_crd
);

    localparam int PROD_W = ntd_pkg::NODE_W + ntd_pkg::RECIP_W;

    logic                          a_valid_reg;
    logic [ntd_pkg::NODE_W-1:0]    a_src_reg;
    logic [ntd_pkg::NODE_W-1:0]    a_q_reg;
    logic [ntd_pkg::NODE_W-1:0]    a_q_next;
    logic [PROD_W-1:0]             a_prod;
    logic                          a_ready;

    logic                          b_valid_reg;
    ntd_pkg::ntd_coord_t           b_crd_reg;
    ntd_pkg::ntd_coord_t           b_crd_next;
    logic                          b_ready;
    logic [ntd_pkg::NODE_W+ntd_pkg::DIM_W-1:0] b_qw;
    logic [ntd_pkg::NODE_W:0]      b_rem;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // The truncated reciprocal gives the quotient or one less than it.
    assign a_prod   = PROD_W'(in_src) * PROD_W'(ntd_pkg::recip(width));
    assign a_q_next = a_prod[ntd_pkg::RECIP_SHIFT +: ntd_pkg::NODE_W];

    always_comb
    begin
        b_qw  = (ntd_pkg::NODE_W+ntd_pkg::DIM_W)'(a_q_reg)
              * (ntd_pkg::NODE_W+ntd_pkg::DIM_W)'(width);
        b_rem = (ntd_pkg::NODE_W+1)'(a_src_reg) - b_qw[ntd_pkg::NODE_W:0];
        b_crd_next.src = a_src_reg;
        if (b_rem >= (ntd_pkg::NODE_W+1)'(width))
        begin
            b_crd_next.sx = ntd_pkg::COORD_W'(b_rem - (ntd_pkg::NODE_W+1)'(width));
            b_crd_next.sy = a_q_reg + 8'd1;
        end
        else
        begin
            b_crd_next.sx = b_rem[ntd_pkg::COORD_W-1:0];
            b_crd_next.sy = a_q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_src_reg <= in_src;
            a_q_reg   <= a_q_next;
        end
        if (b_ready && a_valid_reg)
            b_crd_reg <= b_crd_next;
    end

    assign out_valid = b_valid_reg;
    assign out_crd   = b_crd_reg;

endmodule

// File: rtl/noc_traffic_destination_top.sv
// Synthetic mesh traffic destination generator, top level.
//
// Each word on the src channel carries a source node number; the block answers
// one word on the dst channel with the destination node under the configured
// pattern: transpose1, transpose2, bit reversal, perfect shuffle or butterfly.
// Node ids are row-major over a mesh_width by mesh_height mesh.
// Configuration goes through cfg_we / cfg_index / cfg_data: index 0 is the mesh
// width, 1 the mesh height, 2 the pattern. Write it only while no word is in
// flight.
// A word passes the three register stages in order: reciprocal multiply,
// remainder correction, then pattern and output register. The block takes one
// word per cycle while dst is ready; each stage takes a new word every cycle
// unless the stage ahead of it is stalled.
// Reset clears all valid bits and loads a 4 by 4 mesh with transpose1.
// When the receiver stalls, the output register holds its word and each
// stage keeps its own until the one ahead frees; src stays ready while any
// stage behind a stalled word is empty.
module noc_traffic_destination_top #(
    parameter int MAX_NODES = ntd_pkg::MAX_NODES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ntd_src_if.sink                     src,
    ntd_dst_if.source                   dst,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [ntd_pkg::DIM_W-1:0]   cfg_data
);

    localparam int NODES_W = ntd_pkg::NODE_W + 1;
    localparam int CAP_W   = 13;

    logic [ntd_pkg::DIM_W-1:0]   mesh_width_reg;
    logic [ntd_pkg::DIM_W-1:0]   mesh_height_reg;
    logic [2:0]                  traffic_pattern_reg;

    logic [ntd_pkg::DIM_W-1:0]   w_eff;
    logic [ntd_pkg::DIM_W-1:0]   h_eff;
    logic [NODES_W-1:0]          nodes;
    logic [ntd_pkg::NBITS_W-1:0] nbits;

    logic                        crd_valid;
    logic                        crd_ready;
    ntd_pkg::ntd_coord_t         crd;

    logic                        o_valid_reg;
    logic [ntd_pkg::NODE_W-1:0]  o_dest_reg;
    logic [ntd_pkg::NODE_W-1:0]  o_dest_next;

    logic [ntd_pkg::COORD_W-1:0] dx;
    logic [ntd_pkg::COORD_W-1:0] dy;
    logic [NODES_W-1:0]          trans_dest;
    logic [ntd_pkg::NODE_W-1:0]  bit_dest;

    // ceil(log2(n)) for n from 1 to 256.
    function automatic logic [ntd_pkg::NBITS_W-1:0] clog2_nodes(input logic [NODES_W-1:0] n);
        logic [ntd_pkg::NBITS_W-1:0] r;
        r = '0;
        for (int b = 0; b < NODES_W; b++)
        begin
            if ((NODES_W'(1) << b) < n)
                r = ntd_pkg::NBITS_W'(b + 1);
        end
        return r;
    endfunction

    function automatic logic [ntd_pkg::NODE_W-1:0] bit_reverse(
        input logic [ntd_pkg::NODE_W-1:0] s, input logic [ntd_pkg::NBITS_W-1:0] nb);
        logic [ntd_pkg::NODE_W-1:0]  d;
        logic [ntd_pkg::NBITS_W-1:0] k;
        d = '0;
        for (int i = 0; i < ntd_pkg::NODE_W; i++)
        begin
            k = nb - 4'd1 - ntd_pkg::NBITS_W'(i);
            if (i < int'(nb))
                d[i] = s[k[2:0]];
        end
        return d;
    endfunction

    // Rotate left by one within the low nb bits.
    function automatic logic [ntd_pkg::NODE_W-1:0] shuffle(
        input logic [ntd_pkg::NODE_W-1:0] s, input logic [ntd_pkg::NBITS_W-1:0] nb);
        logic [ntd_pkg::NODE_W-1:0]  d;
        logic [ntd_pkg::NBITS_W-1:0] top;
        d   = '0;
        top = nb - 4'd1;
        for (int i = 0; i < ntd_pkg::NODE_W - 1; i++)
        begin
            if (i + 1 < int'(nb))
                d[i+1] = s[i];
        end
        if (nb != '0)
            d[0] = s[top[2:0]];
        return d;
    endfunction

    // Swap the top and bottom bits within the low nb bits; a single bit stays put.
    function automatic logic [ntd_pkg::NODE_W-1:0] butterfly(
        input logic [ntd_pkg::NODE_W-1:0] s, input logic [ntd_pkg::NBITS_W-1:0] nb);
        logic [ntd_pkg::NODE_W-1:0]  d;
        logic [ntd_pkg::NBITS_W-1:0] top;
        d   = '0;
        top = nb - 4'd1;
        for (int i = 1; i < ntd_pkg::NODE_W - 1; i++)
        begin
            if (i + 1 < int'(nb))
                d[i] = s[i];
        end
        if (nb != '0)
        begin
            d[0]        = s[top[2:0]];
            d[top[2:0]] = s[0];
        end
        return d;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mesh_width_reg      <= ntd_pkg::MESH_WIDTH_RST;
            mesh_height_reg     <= ntd_pkg::MESH_HEIGHT_RST;
            traffic_pattern_reg <= ntd_pkg::PAT_TRANSPOSE1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ntd_pkg::CFG_MESH_WIDTH:      mesh_width_reg      <= cfg_data;
                ntd_pkg::CFG_MESH_HEIGHT:     mesh_height_reg     <= cfg_data;
                ntd_pkg::CFG_TRAFFIC_PATTERN: traffic_pattern_reg <= cfg_data[2:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        w_eff = ntd_pkg::dim_eff(mesh_width_reg);
        h_eff = ntd_pkg::dim_eff(mesh_height_reg);
        nodes = NODES_W'(w_eff) * NODES_W'(h_eff);
        if (CAP_W'(nodes) > CAP_W'(MAX_NODES))
            nodes = NODES_W'(MAX_NODES);
        nbits = clog2_nodes(nodes);
    end

    ntd_divmod u_divmod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (src.valid),
        .in_ready  (src.ready),
        .in_src    (src.source_node),
        .width     (w_eff),
        .out_valid (crd_valid),
        .out_ready (crd_ready),
        .out_crd   (crd)
    );

    assign crd_ready = !o_valid_reg || dst.ready;

    // Transposes clamp into the mesh; the column stays below the width already.
    always_comb
    begin
        if (traffic_pattern_reg == ntd_pkg::PAT_TRANSPOSE1)
        begin
            if (crd.sy >= ntd_pkg::NODE_W'(w_eff))
                dx = '0;
            else
                dx = ntd_pkg::COORD_W'(w_eff - 5'd1 - ntd_pkg::DIM_W'(crd.sy));
            if (ntd_pkg::DIM_W'(crd.sx) >= h_eff)
                dy = '0;
            else
                dy = ntd_pkg::COORD_W'(h_eff - 5'd1 - ntd_pkg::DIM_W'(crd.sx));
        end
        else
        begin
            if (crd.sy >= ntd_pkg::NODE_W'(w_eff))
                dx = ntd_pkg::COORD_W'(w_eff - 5'd1);
            else
                dx = crd.sy[ntd_pkg::COORD_W-1:0];
            if (ntd_pkg::DIM_W'(crd.sx) >= h_eff)
                dy = ntd_pkg::COORD_W'(h_eff - 5'd1);
            else
                dy = crd.sx;
        end
        trans_dest = NODES_W'(dy) * NODES_W'(w_eff) + NODES_W'(dx);

        case (traffic_pattern_reg)
            ntd_pkg::PAT_BIT_REV:   bit_dest = bit_reverse(crd.src, nbits);
            ntd_pkg::PAT_SHUFFLE:   bit_dest = shuffle(crd.src, nbits);
            ntd_pkg::PAT_BUTTERFLY: bit_dest = butterfly(crd.src, nbits);
            default:                bit_dest = '0;
        endcase

        case (traffic_pattern_reg) inside
            ntd_pkg::PAT_TRANSPOSE1,
            ntd_pkg::PAT_TRANSPOSE2: o_dest_next = trans_dest[ntd_pkg::NODE_W-1:0];
            default:                 o_dest_next = bit_dest;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (crd_ready)
            o_valid_reg <= crd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (crd_ready && crd_valid)
            o_dest_reg <= o_dest_next;
    end

    assign dst.valid     = o_valid_reg;
    assign dst.dest_node = o_dest_reg;

`ifndef SYNTH
    // A word reaches the output register only from the coordinate stage.
    a_out_from_crd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(o_valid_reg) |-> $past(crd_valid))
        else $error("output word appeared without a coordinate word behind it");

    // A coordinate word blocked by a full output register is kept intact.
    a_crd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        crd_valid && !crd_ready |=> crd_valid && $stable(crd))
        else $error("coordinate word lost or changed while stalled");

    // Bit patterns never set bits at or above the address width.
    a_bits_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_dest >> nbits) == '0)
        else $error("bit pattern result wider than the node address");
`endif

endmodule
